// ===== hw/rtl/smeu_pkg.sv =====
// Shared constants, opcodes, fault codes and control types of the stack machine execute unit.
// No dependencies; compile first.
package smeu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = SP_W + 1;
  localparam int PC_W        = 16;
  localparam int WORD_W      = 32;
  localparam int OP_W        = 5;
  localparam int CHAR_W      = 9;
  localparam int FAULT_W     = 3;

  localparam logic [OP_W-1:0] OP_HALT   = 5'd0;
  localparam logic [OP_W-1:0] OP_JUMP   = 5'd1;
  localparam logic [OP_W-1:0] OP_JNZ    = 5'd2;
  localparam logic [OP_W-1:0] OP_DUP    = 5'd3;
  localparam logic [OP_W-1:0] OP_SWAP   = 5'd4;
  localparam logic [OP_W-1:0] OP_DROP   = 5'd5;
  localparam logic [OP_W-1:0] OP_PUSH4  = 5'd6;
  localparam logic [OP_W-1:0] OP_PUSH2  = 5'd7;
  localparam logic [OP_W-1:0] OP_PUSH1  = 5'd8;
  localparam logic [OP_W-1:0] OP_ADD    = 5'd9;
  localparam logic [OP_W-1:0] OP_SUB    = 5'd10;
  localparam logic [OP_W-1:0] OP_MUL    = 5'd11;
  localparam logic [OP_W-1:0] OP_DIV    = 5'd12;
  localparam logic [OP_W-1:0] OP_MOD    = 5'd13;
  localparam logic [OP_W-1:0] OP_EQ     = 5'd14;
  localparam logic [OP_W-1:0] OP_NE     = 5'd15;
  localparam logic [OP_W-1:0] OP_LT     = 5'd16;
  localparam logic [OP_W-1:0] OP_GT     = 5'd17;
  localparam logic [OP_W-1:0] OP_LE     = 5'd18;
  localparam logic [OP_W-1:0] OP_GE     = 5'd19;
  localparam logic [OP_W-1:0] OP_NOT    = 5'd20;
  localparam logic [OP_W-1:0] OP_AND    = 5'd21;
  localparam logic [OP_W-1:0] OP_OR     = 5'd22;
  localparam logic [OP_W-1:0] OP_INPUT  = 5'd23;
  localparam logic [OP_W-1:0] OP_OUTPUT = 5'd24;

  localparam logic [FAULT_W-1:0] FAULT_NONE    = 3'd0;
  localparam logic [FAULT_W-1:0] FAULT_INVALID = 3'd1;
  localparam logic [FAULT_W-1:0] FAULT_UNDER   = 3'd2;
  localparam logic [FAULT_W-1:0] FAULT_OVER    = 3'd3;
  localparam logic [FAULT_W-1:0] FAULT_DIVZERO = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD1, ST_RD2, ST_OPA, ST_EXEC, ST_DIV, ST_WR2, ST_TOPRD, ST_TOPLAT
  } state_e;

  typedef enum logic [1:0] {RD_OPB, RD_OPA, RD_TOP} rd_sel_e;

  typedef struct packed {
    logic    load_item;
    rd_sel_e rd_sel;
    logic    lat_b;
    logic    lat_a;
    logic    exec;
    logic    div_commit;
    logic    wr_swap2;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic swap2;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/smeu_if.sv =====
// Valid/ready channel interfaces for instruction beats and result beats.
// Depends on smeu_pkg.
interface smeu_in_if import smeu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          func;
  logic [WORD_W-1:0]        immediate;
  logic signed [CHAR_W-1:0] in_char;

  modport source (output valid, func, immediate, in_char, input ready);
  modport sink   (input valid, func, immediate, in_char, output ready);
endinterface

interface smeu_out_if import smeu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          next_pc;
  logic                     out_valid;
  logic [7:0]               out_char;
  logic                     halted;
  logic [FAULT_W-1:0]       fault;
  logic signed [WORD_W-1:0] top_value;

  modport source (output valid, next_pc, out_valid, out_char, halted, fault, top_value,
                  input ready);
  modport sink   (input valid, next_pc, out_valid, out_char, halted, fault, top_value,
                  output ready);
endinterface

// ===== hw/rtl/smeu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/smeu_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on smeu_pkg.
module smeu_div import smeu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [WORD_W-1:0] divisor_i,
  output logic              done_o,
  output logic [WORD_W-1:0] quot_o,
  output logic [WORD_W-1:0] rem_o
);
  localparam int CNT_W = $clog2(WORD_W);

  logic              run_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] quo_q, dvs_q;
  logic [WORD_W:0]   rem_q;
  logic [WORD_W:0]   shifted, trial;

  assign shifted = {rem_q[WORD_W-1:0], quo_q[WORD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      if (!trial[WORD_W]) begin
        rem_q <= trial;
        quo_q <= {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[WORD_W-1:0];
endmodule

// ===== hw/rtl/smeu_dp.sv =====
// Datapath: instruction latch, stack RAM, ALU, divider, architectural state, result register.
// Depends on smeu_pkg, smeu_if, smeu_ram and smeu_div.
module smeu_dp import smeu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  smeu_in_if.sink   in_i,
  smeu_out_if.source out_o
);
  logic [OP_W-1:0]    op_q;
  logic [WORD_W-1:0]  imm_q, b_q, a_q;
  logic [CHAR_W-1:0]  ch_q;
  logic [DEPTH_W-1:0] depth_q, depth_n;
  logic [PC_W-1:0]    pc_q, pc_n;
  logic               stopped_q;
  logic [FAULT_W-1:0] fault, res_fault_q;
  logic               res_ov_q;
  logic [7:0]         res_oc_q;

  logic               ovld_q, o_ov_q, o_halt_q;
  logic [PC_W-1:0]    o_pc_q;
  logic [7:0]         o_oc_q;
  logic [FAULT_W-1:0] o_fault_q;
  logic [WORD_W-1:0]  o_top_q;

  logic [SP_W-1:0]    d_m1, d_m2, d_mk, raddr, waddr, x_waddr;
  logic [WORD_W-1:0]  rdata, wdata, x_wdata, alu_r, push_v, mul_r;
  logic               we, x_we, is_bin, empty, full, need_div, commit;
  logic [DEPTH_W-1:0] k9;
  logic               div_done;
  logic [WORD_W-1:0]  ma, mb, quot, remd, div_r;

  assign k9    = {1'b0, imm_q[7:0]};
  assign d_m1  = SP_W'(depth_q - 1'b1);
  assign d_m2  = SP_W'(depth_q - 2'd2);
  assign d_mk  = SP_W'(depth_q - 1'b1 - k9);
  assign empty = (depth_q == '0);
  assign full  = (depth_q >= DEPTH_W'(STACK_DEPTH));
  assign is_bin = (op_q >= OP_ADD && op_q <= OP_GE) || op_q == OP_AND || op_q == OP_OR;
  assign mul_r = a_q * b_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_OPB:  raddr = (op_q == OP_DUP || op_q == OP_SWAP) ? d_mk : d_m1;
      RD_OPA:  raddr = (op_q == OP_SWAP) ? d_m1 : d_m2;
      default: raddr = d_m1;
    endcase
  end

  always_comb begin
    case (op_q)
      OP_PUSH4: push_v = imm_q;
      OP_PUSH2: push_v = {16'd0, imm_q[15:0]};
      OP_PUSH1: push_v = {24'd0, imm_q[7:0]};
      default:  push_v = {{(WORD_W-CHAR_W){ch_q[CHAR_W-1]}}, ch_q};
    endcase
  end

  always_comb begin
    case (op_q)
      OP_ADD:  alu_r = a_q + b_q;
      OP_SUB:  alu_r = a_q - b_q;
      OP_MUL:  alu_r = mul_r;
      OP_EQ:   alu_r = WORD_W'(a_q == b_q);
      OP_NE:   alu_r = WORD_W'(a_q != b_q);
      OP_LT:   alu_r = WORD_W'($signed(a_q) < $signed(b_q));
      OP_GT:   alu_r = WORD_W'($signed(a_q) > $signed(b_q));
      OP_LE:   alu_r = WORD_W'($signed(a_q) <= $signed(b_q));
      OP_GE:   alu_r = WORD_W'($signed(a_q) >= $signed(b_q));
      OP_AND:  alu_r = WORD_W'(a_q != '0 && b_q != '0);
      default: alu_r = WORD_W'(a_q != '0 || b_q != '0);
    endcase
  end

  // Per-opcode fault check, next pc/depth and the single stack write.
  always_comb begin
    fault   = FAULT_NONE;
    pc_n    = pc_q + 1'b1;
    depth_n = depth_q;
    x_we    = 1'b0;
    x_waddr = depth_q[SP_W-1:0];
    x_wdata = push_v;
    case (op_q)
      OP_HALT: pc_n = pc_q;
      OP_JUMP: pc_n = imm_q[PC_W-1:0];
      OP_JNZ: begin
        if (empty) fault = FAULT_UNDER;
        depth_n = depth_q - 1'b1;
        pc_n    = (b_q != '0) ? imm_q[PC_W-1:0] : pc_q + 2'd3;
      end
      OP_DUP: begin
        if (k9 >= depth_q) fault = FAULT_UNDER;
        else if (full) fault = FAULT_OVER;
        depth_n = depth_q + 1'b1;
        pc_n    = pc_q + 2'd2;
        x_we    = 1'b1;
        x_wdata = b_q;
      end
      OP_SWAP: begin
        if (k9 >= depth_q) fault = FAULT_UNDER;
        pc_n    = pc_q + 2'd2;
        x_we    = 1'b1;
        x_waddr = d_mk;
        x_wdata = a_q;
      end
      OP_DROP, OP_OUTPUT: begin
        if (empty) fault = FAULT_UNDER;
        depth_n = depth_q - 1'b1;
      end
      OP_PUSH4, OP_PUSH2, OP_PUSH1, OP_INPUT: begin
        if (full) fault = FAULT_OVER;
        depth_n = depth_q + 1'b1;
        x_we    = 1'b1;
        case (op_q)
          OP_PUSH4: pc_n = pc_q + 3'd5;
          OP_PUSH2: pc_n = pc_q + 2'd3;
          OP_PUSH1: pc_n = pc_q + 2'd2;
          default:  pc_n = pc_q + 1'b1;
        endcase
      end
      OP_NOT: begin
        if (empty) fault = FAULT_UNDER;
        x_we    = 1'b1;
        x_waddr = d_m1;
        x_wdata = WORD_W'(b_q == '0);
      end
      default: begin
        if (!is_bin) begin
          fault = FAULT_INVALID;
        end else begin
          if (depth_q < DEPTH_W'(2)) fault = FAULT_UNDER;
          else if ((op_q == OP_DIV || op_q == OP_MOD) && b_q == '0) fault = FAULT_DIVZERO;
          depth_n = depth_q - 1'b1;
          x_we    = 1'b1;
          x_waddr = d_m2;
          x_wdata = alu_r;
        end
      end
    endcase
  end

  assign need_div = !stopped_q && fault == FAULT_NONE && (op_q == OP_DIV || op_q == OP_MOD);
  assign commit   = cmd_i.exec && !stopped_q && !need_div;

  assign ma = a_q[WORD_W-1] ? -a_q : a_q;
  assign mb = b_q[WORD_W-1] ? -b_q : b_q;

  smeu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.exec && need_div),
    .dividend_i (ma),
    .divisor_i  (mb),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (remd)
  );

  always_comb begin
    if (op_q == OP_DIV) div_r = (a_q[WORD_W-1] ^ b_q[WORD_W-1]) ? -quot : quot;
    else                div_r = a_q[WORD_W-1] ? -remd : remd;
  end

  always_comb begin
    we    = 1'b0;
    waddr = x_waddr;
    wdata = x_wdata;
    if (commit && fault == FAULT_NONE && x_we) begin
      we = 1'b1;
    end else if (cmd_i.div_commit) begin
      we    = 1'b1;
      waddr = d_m2;
      wdata = div_r;
    end else if (cmd_i.wr_swap2) begin
      we    = 1'b1;
      waddr = d_m1;
      wdata = b_q;
    end
  end

  smeu_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= '0;
      pc_q      <= '0;
      stopped_q <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      if (commit) begin
        if (fault == FAULT_NONE) begin
          depth_q <= depth_n;
          pc_q    <= pc_n;
        end
        if (fault != FAULT_NONE || op_q == OP_HALT) stopped_q <= 1'b1;
      end else if (cmd_i.div_commit) begin
        depth_q <= depth_q - 1'b1;
        pc_q    <= pc_q + 1'b1;
      end
      if (cmd_i.out_load)  ovld_q <= 1'b1;
      else if (out_o.ready) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= in_i.func;
      imm_q <= in_i.immediate;
      ch_q  <= in_i.in_char;
    end
    if (cmd_i.lat_b) b_q <= rdata;
    if (cmd_i.lat_a) a_q <= rdata;
    if (cmd_i.exec) begin
      res_fault_q <= stopped_q ? FAULT_NONE : fault;
      res_ov_q    <= !stopped_q && fault == FAULT_NONE && op_q == OP_OUTPUT;
      res_oc_q    <= (!stopped_q && fault == FAULT_NONE && op_q == OP_OUTPUT) ? b_q[7:0] : 8'd0;
    end
    if (cmd_i.out_load) begin
      o_pc_q    <= pc_q;
      o_ov_q    <= res_ov_q;
      o_oc_q    <= res_oc_q;
      o_halt_q  <= stopped_q;
      o_fault_q <= res_fault_q;
      o_top_q   <= empty ? '0 : rdata;
    end
  end

  assign sts_o.need_div = need_div;
  assign sts_o.swap2    = !stopped_q && fault == FAULT_NONE && op_q == OP_SWAP;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ovld_q || out_o.ready;

  assign out_o.valid     = ovld_q;
  assign out_o.next_pc   = o_pc_q;
  assign out_o.out_valid = o_ov_q;
  assign out_o.out_char  = o_oc_q;
  assign out_o.halted    = o_halt_q;
  assign out_o.fault     = o_fault_q;
  assign out_o.top_value = o_top_q;
endmodule

// ===== hw/rtl/smeu_ctrl.sv =====
// Controller state machine: sequences stack reads, execute, divide, writes and result load.
// Depends on smeu_pkg.
module smeu_ctrl import smeu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_RD1;
      ST_RD1:    state_d = ST_RD2;
      ST_RD2:    state_d = ST_OPA;
      ST_OPA:    state_d = ST_EXEC;
      ST_EXEC: begin
        if (sts_i.need_div)   state_d = ST_DIV;
        else if (sts_i.swap2) state_d = ST_WR2;
        else                  state_d = ST_TOPRD;
      end
      ST_DIV:    if (sts_i.div_done) state_d = ST_TOPRD;
      ST_WR2:    state_d = ST_TOPRD;
      ST_TOPRD:  state_d = ST_TOPLAT;
      ST_TOPLAT: if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.rd_sel = RD_TOP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_RD1:  cmd_o.rd_sel = RD_OPB;
      ST_RD2: begin
        cmd_o.rd_sel = RD_OPA;
        cmd_o.lat_b  = 1'b1;
      end
      ST_OPA:    cmd_o.lat_a = 1'b1;
      ST_EXEC:   cmd_o.exec = 1'b1;
      ST_DIV:    cmd_o.div_commit = sts_i.div_done;
      ST_WR2:    cmd_o.wr_swap2 = 1'b1;
      ST_TOPRD:  cmd_o.rd_sel = RD_TOP;
      ST_TOPLAT: cmd_o.out_load = sts_i.out_free;
      default:   cmd_o = '0;
    endcase
  end
endmodule

// ===== hw/rtl/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit: controller plus datapath.
// Depends on smeu_pkg, smeu_if, smeu_ctrl and smeu_dp.
//
//  channel | dir | handshake   | payload
//  in_i    | in  | valid/ready | func, immediate, in_char
//  out_o   | out | valid/ready | next_pc, out_valid, out_char, halted, fault, top_value
//
// An accepted instruction beat runs through reads of operand b and operand a, execute,
// a second stack write for swap or the one-bit-per-cycle divider for div and mod,
// a read of the new top and the result load; only then is the next beat taken. The single
// read port of the stack RAM is why both operands and the new top are read in turn.
// rst_ni clears depth, pc, the stopped flag, the FSM and the result valid; the stack
// RAM itself is not cleared. A stalled result beat holds in the output register while
// the next instruction beat is accepted and run up to its own result load.
module stack_machine_execute_unit import smeu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  smeu_in_if.sink    in_i,
  smeu_out_if.source out_o
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence each beat through read, execute and write-back.
  smeu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold stack, pc and result register.
  smeu_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o)
  );
endmodule

// ===== tb/tb_smeu_if.sv =====
// Testbench copies of the instruction and result channel interfaces are not needed;
// this file holds only the result_t struct that the bench uses for result beats.
// Depends on smeu_pkg from the RTL.
package tb_smeu_types;
  import smeu_pkg::*;
  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               out_valid;
    logic [7:0]         out_char;
    logic               halted;
    logic [FAULT_W-1:0] fault;
    logic [WORD_W-1:0]  top_value;
  } result_t;
endpackage

// ===== tb/tb_stack_machine_execute_unit.sv =====
// Regression bench for stack_machine_execute_unit: drives instruction beats, predicts each
// result beat with a local machine model and compares it as one packed result.
// Depends on smeu_pkg, smeu_if, the RTL and tb_smeu_types.
module tb_stack_machine_execute_unit;
  import smeu_pkg::*;
  import tb_smeu_types::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  smeu_in_if  in_ch ();
  smeu_out_if out_ch ();

  stack_machine_execute_unit dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  localparam logic [OP_W-1:0] OP_BAD = 5'd31;

  // Shadow machine state.
  logic [WORD_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned       shadow_depth;
  logic [PC_W-1:0]   shadow_pc;
  bit                shadow_stopped;

  result_t expected_q [$];
  int      mismatch_cnt;
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      recv_hold;
  int      quiet_cycles;
  localparam int WATCHDOG_LIMIT = 20000;

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.func      = '0;
    in_ch.immediate = '0;
    in_ch.in_char   = '0;
    out_ch.ready    = 1'b0;
  end

  function automatic logic [WORD_W-1:0] shadow_top();
    return (shadow_depth == 0) ? '0 : shadow_stack[shadow_depth-1];
  endfunction

  // Execute one instruction on the shadow machine and queue its result.
  function automatic void predict_step(logic [OP_W-1:0] op, logic [WORD_W-1:0] imm,
                                       logic signed [CHAR_W-1:0] ch);
    result_t r;
    logic [FAULT_W-1:0] flt;
    int unsigned d, k;
    logic [WORD_W-1:0] a, b, v, t, res;
    logic signed [WORD_W-1:0] sa, sb;
    logic [WORD_W-1:0] ma, mb, q;
    int unsigned len;
    flt = FAULT_NONE;
    d = shadow_depth;
    k = imm[7:0];
    r = '0;
    if (!shadow_stopped) begin
      case (op)
        OP_HALT: shadow_stopped = 1'b1;
        OP_JUMP: shadow_pc = imm[15:0];
        OP_JNZ: begin
          if (d < 1) flt = FAULT_UNDER;
          else begin
            shadow_depth = d - 1;
            shadow_pc = (shadow_stack[d-1] != 0) ? imm[15:0] : shadow_pc + 16'd3;
          end
        end
        OP_DUP: begin
          if (k >= d) flt = FAULT_UNDER;
          else if (d >= STACK_DEPTH) flt = FAULT_OVER;
          else begin
            shadow_stack[d] = shadow_stack[d-1-k];
            shadow_depth = d + 1;
            shadow_pc += 16'd2;
          end
        end
        OP_SWAP: begin
          if (k >= d) flt = FAULT_UNDER;
          else begin
            t = shadow_stack[d-1-k];
            shadow_stack[d-1-k] = shadow_stack[d-1];
            shadow_stack[d-1] = t;
            shadow_pc += 16'd2;
          end
        end
        OP_DROP: begin
          if (d < 1) flt = FAULT_UNDER;
          else begin
            shadow_depth = d - 1;
            shadow_pc += 16'd1;
          end
        end
        OP_PUSH4, OP_PUSH2, OP_PUSH1, OP_INPUT: begin
          case (op)
            OP_PUSH4: begin v = imm; len = 5; end
            OP_PUSH2: begin v = {16'd0, imm[15:0]}; len = 3; end
            OP_PUSH1: begin v = {24'd0, imm[7:0]}; len = 2; end
            default:  begin v = {{(WORD_W-CHAR_W){ch[CHAR_W-1]}}, ch}; len = 1; end
          endcase
          if (d >= STACK_DEPTH) flt = FAULT_OVER;
          else begin
            shadow_stack[d] = v;
            shadow_depth = d + 1;
            shadow_pc += len[PC_W-1:0];
          end
        end
        OP_NOT: begin
          if (d < 1) flt = FAULT_UNDER;
          else begin
            shadow_stack[d-1] = (shadow_stack[d-1] == 0) ? 32'd1 : 32'd0;
            shadow_pc += 16'd1;
          end
        end
        OP_OUTPUT: begin
          if (d < 1) flt = FAULT_UNDER;
          else begin
            r.out_valid = 1'b1;
            r.out_char = shadow_stack[d-1][7:0];
            shadow_depth = d - 1;
            shadow_pc += 16'd1;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_LT, OP_GT, OP_LE,
        OP_GE, OP_AND, OP_OR: begin
          if (d < 2) flt = FAULT_UNDER;
          else begin
            b = shadow_stack[d-1];
            a = shadow_stack[d-2];
            sa = a;
            sb = b;
            res = '0;
            case (op)
              OP_ADD: res = a + b;
              OP_SUB: res = a - b;
              OP_MUL: res = a * b;
              OP_DIV, OP_MOD: begin
                if (b == 0) flt = FAULT_DIVZERO;
                else begin
                  ma = a[31] ? -a : a;
                  mb = b[31] ? -b : b;
                  if (op == OP_DIV) begin
                    q = ma / mb;
                    res = (a[31] ^ b[31]) ? -q : q;
                  end else begin
                    q = ma % mb;
                    res = a[31] ? -q : q;
                  end
                end
              end
              OP_EQ:  res = {31'd0, a == b};
              OP_NE:  res = {31'd0, a != b};
              OP_LT:  res = {31'd0, sa < sb};
              OP_GT:  res = {31'd0, sa > sb};
              OP_LE:  res = {31'd0, sa <= sb};
              OP_GE:  res = {31'd0, sa >= sb};
              OP_AND: res = {31'd0, (a != 0) && (b != 0)};
              default: res = {31'd0, (a != 0) || (b != 0)};
            endcase
            if (flt == FAULT_NONE) begin
              shadow_stack[d-2] = res;
              shadow_depth = d - 1;
              shadow_pc += 16'd1;
            end
          end
        end
        default: flt = FAULT_INVALID;
      endcase
      if (flt != FAULT_NONE) shadow_stopped = 1'b1;
    end
    r.next_pc = shadow_pc;
    r.halted = shadow_stopped;
    r.fault = flt;
    r.top_value = shadow_top();
    expected_q.push_back(r);
  endfunction

  // Offer one instruction beat with random idle gaps, hold until accepted.
  task automatic send_instr(logic [OP_W-1:0] op, logic [WORD_W-1:0] imm,
                            logic signed [CHAR_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= op;
    in_ch.immediate <= imm;
    in_ch.in_char   <= ch;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_step(op, imm, ch);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Walk the machine through pushes, shuffles, the division corner cases and
  // character i/o without stopping it.
  task automatic test_directed();
    send_instr(OP_PUSH1, 32'hFFFF_FFAB, '0);
    send_instr(OP_PUSH2, 32'h1234_FFFF, '0);
    send_instr(OP_PUSH4, 32'hFFFF_FFFF, '0);
    send_instr(OP_PUSH4, 32'h8000_0000, '0);
    send_instr(OP_DUP, 32'h0000_0001, '0);
    send_instr(OP_SWAP, 32'h0000_0002, '0);
    send_instr(OP_SWAP, 32'h0000_0002, '0);
    send_instr(OP_DIV, '0, '0);
    send_instr(OP_INPUT, '0, -9'sd1);
    send_instr(OP_MOD, '0, '0);
    send_instr(OP_INPUT, '0, 9'sd255);
    send_instr(OP_OUTPUT, '0, '0);
    send_instr(OP_ADD, '0, '0);
    send_instr(OP_NOT, '0, '0);
    send_instr(OP_JNZ, 32'h0000_ABCD, '0);
    send_instr(OP_JUMP, 32'hFFFF_FFFF, '0);
    send_instr(OP_PUSH1, '0, '0);
    send_instr(OP_JNZ, 32'h0000_0010, '0);
  endtask

  // Send one random instruction that keeps the machine running: no halt, no invalid
  // opcode, enough operands, room to push and a nonzero divisor.
  task automatic rand_step();
    logic [OP_W-1:0]          op;
    logic [WORD_W-1:0]        imm;
    logic signed [CHAR_W-1:0] ch;
    bit                       ok;
    imm = $urandom;
    ch  = CHAR_W'(int'($urandom_range(256)) - 1);
    op  = OP_PUSH1;
    ok  = 1'b0;
    while (!ok) begin
      op = OP_W'($urandom_range(24, 1));
      case (op)
        OP_JUMP:                                ok = 1'b1;
        OP_JNZ, OP_DROP, OP_NOT, OP_OUTPUT,
        OP_SWAP:                                ok = (shadow_depth >= 1);
        OP_DUP:                                 ok = (shadow_depth >= 1) &&
                                                     (shadow_depth < STACK_DEPTH);
        OP_PUSH4, OP_PUSH2, OP_PUSH1, OP_INPUT: ok = (shadow_depth < STACK_DEPTH);
        OP_DIV, OP_MOD:                         ok = (shadow_depth >= 2) &&
                                                     (shadow_stack[shadow_depth-1] != 0);
        default:                                ok = (shadow_depth >= 2);
      endcase
    end
    if (op == OP_DUP || op == OP_SWAP) imm[7:0] = 8'($urandom_range(shadow_depth - 1));
    send_instr(op, imm, ch);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) rand_step();
  endtask

  task automatic test_backpressure();
    recv_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      test_random(20);
    join
    wait_drained();
  endtask

  // Stop the machine with a fault, then check that later beats change nothing.
  task automatic test_stop();
    send_instr(OP_PUSH1, '0, '0);
    send_instr(OP_PUSH1, '0, '0);
    send_instr(OP_DIV, '0, '0);
    send_instr(OP_ADD, '0, '0);
    send_instr(OP_BAD, '0, '0);
    send_instr(OP_HALT, '0, '0);
  endtask

  // Check result beats against the oldest prediction.
  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.next_pc, out_ch.out_valid, out_ch.out_char, out_ch.halted,
             out_ch.fault, out_ch.top_value};
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %h actual %h", exp_r, got);
        end
      end
    end
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stack_machine_execute_unit regression: fail");
      $finish;
    end
  end

  initial begin
    mismatch_cnt = 0;
    quiet_cycles = 0;
    recv_hold = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 70;
    for (int i = 0; i < STACK_DEPTH; i++) shadow_stack[i] = '0;
    shadow_depth = 0;
    shadow_pc = '0;
    shadow_stopped = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(550);
    send_idle_pct = 70;
    recv_idle_pct = 37;
    test_random(550);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(550);
    test_stop();
    wait_drained();
    if (mismatch_cnt == 0 && expected_q.size() == 0)
      $display("stack_machine_execute_unit regression: pass");
    else
      $display("stack_machine_execute_unit regression: fail");
    $finish;
  end
endmodule
